>>> design/lrm_pkg.sv
package lrm_pkg;

  localparam int MAX_REGIONS_DEF = 64;
  localparam int MAX_PIXELS_DEF  = 1048576;

  localparam int PIX_W   = 32;
  localparam int LABEL_W = 8;
  localparam int IDX_W   = 6;
  localparam int CNT_O_W = 21;
  localparam int NREG_W  = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [NREG_W-1:0] NREG_RESET = NREG_W'(64);

  localparam logic STAT_MEAN = 1'b0;
  localparam logic STAT_ERR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_RD,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } lrm_state_t;

  typedef struct packed {
    logic start;
  } lrm_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lrm_div_sts_t;

endpackage

>>> design/lrm_if.sv
interface lrm_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [lrm_pkg::PIX_W-1:0] pixel_value;
  logic [lrm_pkg::LABEL_W-1:0]      region_label;
  logic                             last_pixel;

  modport source (output valid, pixel_value, region_label, last_pixel, input ready);
  modport sink   (input valid, pixel_value, region_label, last_pixel, output ready);
endinterface

interface lrm_out_if;
  logic                             valid;
  logic                             ready;
  logic [lrm_pkg::IDX_W-1:0]        region_index;
  logic signed [lrm_pkg::PIX_W-1:0] mean_value;
  logic [lrm_pkg::CNT_O_W-1:0]      pixel_count;
  logic                             status;
  logic                             last_result;

  modport source (output valid, region_index, mean_value, pixel_count, status, last_result,
                  input ready);
  modport sink   (input valid, region_index, mean_value, pixel_count, status, last_result,
                  output ready);
endinterface

>>> design/lrm_ram.sv
module lrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/lrm_div.sv
module lrm_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 21
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lrm_pkg::lrm_div_ctl_t ctl,
  input  logic [NUM_W-1:0]      num,
  input  logic [DEN_W-1:0]      den,
  output lrm_pkg::lrm_div_sts_t sts,
  output logic [NUM_W-1:0]      quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, q_r[NUM_W-1]};
    ge       = rem_sh >= {1'b0, den_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctl.start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        q_nxt   = {q_r[NUM_W-2:0], ge};
        rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (ctl.start) begin
      den_r <= den;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = busy_r && (cnt_r == '0);
  assign quo      = q_r;

endmodule

>>> design/labeled_region_mean.sv
// Per-label region mean. Each accepted pixel request is a signed Q16.16 sample with a
// region label; the block keeps a running sum and count per region in one on-chip RAM
// and handles a good label as a RAM read, then an add and write back; a bad one gives an
// error result that must leave the output register before the next request is taken. On
// the last pixel it emits one mean per region 0 .. N-1, N being num_regions clamped to
// 1 .. MAX_REGIONS, each from a divider giving one quotient bit per cycle over the sum
// width. A label at or above N gives an error result (status 1) except on the last pixel,
// where it is dropped. Sums and counts read as zero after reset and after each frame
// through per-entry valid bits, so no clearing pass is needed. num_regions (APB address 0)
// must be written only while the block is idle; the block itself does not enforce it.
module labeled_region_mean #(
  parameter int MAX_REGIONS = lrm_pkg::MAX_REGIONS_DEF,
  parameter int MAX_PIXELS  = lrm_pkg::MAX_PIXELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lrm_in_if.sink                      in_px,
  lrm_out_if.source                   out_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrm_pkg::PADDR_W-1:0] paddr,
  input  logic [lrm_pkg::PDATA_W-1:0] pwdata,
  output logic [lrm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int AW    = $clog2(MAX_REGIONS);
  localparam int CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W = 31 + CNT_W;
  localparam int PW    = lrm_pkg::PIX_W;
  localparam int NW    = lrm_pkg::NREG_W;

  lrm_pkg::lrm_state_t state_r, state_nxt;

  logic [NW-1:0]          nreg_r;
  logic [PW-1:0]          val_r;
  logic [lrm_pkg::LABEL_W-1:0] lab_r;
  logic                   last_r;
  logic [AW-1:0]          j_r, j_nxt;
  logic [MAX_REGIONS-1:0] vld_r, vld_nxt;
  logic [CNT_W-1:0]       cnt_r;
  logic                   neg_r;

  logic                   ov_r;
  logic [lrm_pkg::IDX_W-1:0]   oidx_r;
  logic [PW-1:0]          omean_r;
  logic [lrm_pkg::CNT_O_W-1:0] ocnt_r;
  logic                   ostat_r, olast_r;

  logic                   acc, out_free, out_ld;
  logic [NW-1:0]          eff;
  logic                   bad, j_last;

  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [SUM_W+CNT_W-1:0] wdata, rdata;
  logic [SUM_W-1:0]       e_sum, mag;
  logic [CNT_W-1:0]       e_cnt;
  logic                   e_vld;
  logic [AW-1:0]          e_addr;

  lrm_pkg::lrm_div_ctl_t  dctl;
  lrm_pkg::lrm_div_sts_t  dsts;
  logic [SUM_W-1:0]       quo;
  logic [PW-1:0]          mean;

  logic [lrm_pkg::IDX_W-1:0]   n_oidx;
  logic [PW-1:0]          n_omean;
  logic [lrm_pkg::CNT_O_W-1:0] n_ocnt;
  logic                   n_ostat, n_olast;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? lrm_pkg::PDATA_W'(nreg_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nreg_r <= lrm_pkg::NREG_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      nreg_r <= pwdata[NW-1:0];
    end
  end

  always_comb begin
    if (nreg_r == '0) begin
      eff = NW'(1);
    end else if (nreg_r > NW'(MAX_REGIONS)) begin
      eff = NW'(MAX_REGIONS);
    end else begin
      eff = nreg_r;
    end
  end

  assign in_px.ready = (state_r == lrm_pkg::ST_IDLE) && !ov_r;
  assign acc         = in_px.valid && in_px.ready;
  assign out_free    = !ov_r || out_res.ready;
  assign bad         = in_px.region_label >= lrm_pkg::LABEL_W'(eff);
  assign j_last      = NW'(j_r) == (eff - 1'b1);

  lrm_ram #(
    .WIDTH (SUM_W + CNT_W),
    .DEPTH (MAX_REGIONS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  lrm_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dctl),
    .num   (mag),
    .den   (e_cnt),
    .sts   (dsts),
    .quo   (quo)
  );

  // entry read back, invalid entries read as zero
  assign e_addr = (state_r == lrm_pkg::ST_ACC) ? lab_r[AW-1:0] : j_r;
  assign e_vld  = vld_r[e_addr];
  assign e_sum  = e_vld ? rdata[SUM_W+CNT_W-1:CNT_W] : '0;
  assign e_cnt  = e_vld ? rdata[CNT_W-1:0] : '0;
  assign mag    = e_sum[SUM_W-1] ? (~e_sum + 1'b1) : e_sum;
  assign mean   = (cnt_r == '0) ? '0 : (neg_r ? (~quo[PW-1:0] + 1'b1) : quo[PW-1:0]);
  assign raddr  = (state_r == lrm_pkg::ST_IDLE) ? in_px.region_label[AW-1:0] : j_r;
  assign waddr  = lab_r[AW-1:0];
  assign wdata  = {e_sum + {{(SUM_W-PW){val_r[PW-1]}}, val_r}, e_cnt + 1'b1};

  always_comb begin
    state_nxt  = state_r;
    j_nxt      = j_r;
    vld_nxt    = vld_r;
    we         = 1'b0;
    dctl.start = 1'b0;
    out_ld     = 1'b0;
    n_oidx     = oidx_r;
    n_omean    = omean_r;
    n_ocnt     = ocnt_r;
    n_ostat    = ostat_r;
    n_olast    = olast_r;
    unique case (state_r)
      lrm_pkg::ST_IDLE: begin
        if (acc) begin
          j_nxt = '0;
          if (!bad) begin
            state_nxt = lrm_pkg::ST_ACC;
          end else if (in_px.last_pixel) begin
            state_nxt = lrm_pkg::ST_RD;
          end else begin
            out_ld  = 1'b1;
            n_oidx  = in_px.region_label[lrm_pkg::IDX_W-1:0];
            n_omean = '0;
            n_ocnt  = '0;
            n_ostat = lrm_pkg::STAT_ERR;
            n_olast = 1'b0;
          end
        end
      end
      lrm_pkg::ST_ACC: begin
        if (e_cnt < CNT_W'(MAX_PIXELS)) begin
          we             = 1'b1;
          vld_nxt[waddr] = 1'b1;
        end
        state_nxt = last_r ? lrm_pkg::ST_RD : lrm_pkg::ST_IDLE;
      end
      lrm_pkg::ST_RD: begin
        state_nxt = lrm_pkg::ST_LOAD;
      end
      lrm_pkg::ST_LOAD: begin
        dctl.start = 1'b1;
        state_nxt  = lrm_pkg::ST_DIV;
      end
      lrm_pkg::ST_DIV: begin
        if (dsts.done) begin
          state_nxt = lrm_pkg::ST_EMIT;
        end
      end
      lrm_pkg::ST_EMIT: begin
        if (out_free) begin
          out_ld  = 1'b1;
          n_oidx  = lrm_pkg::IDX_W'(j_r);
          n_omean = mean;
          n_ocnt  = lrm_pkg::CNT_O_W'(cnt_r);
          n_ostat = lrm_pkg::STAT_MEAN;
          n_olast = j_last;
          if (j_last) begin
            vld_nxt   = '0;
            state_nxt = lrm_pkg::ST_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = lrm_pkg::ST_RD;
          end
        end
      end
      default: state_nxt = lrm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrm_pkg::ST_IDLE;
      vld_r   <= '0;
      ov_r    <= 1'b0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      j_r     <= j_nxt;
      if (out_ld) begin
        ov_r <= 1'b1;
      end else if (out_res.ready) begin
        ov_r <= 1'b0;
      end
    end
    if (acc) begin
      val_r  <= in_px.pixel_value;
      lab_r  <= in_px.region_label;
      last_r <= in_px.last_pixel;
    end
    if (dctl.start) begin
      cnt_r <= e_cnt;
      neg_r <= e_sum[SUM_W-1];
    end
    if (out_ld) begin
      oidx_r  <= n_oidx;
      omean_r <= n_omean;
      ocnt_r  <= n_ocnt;
      ostat_r <= n_ostat;
      olast_r <= n_olast;
    end
  end

  assign out_res.valid        = ov_r;
  assign out_res.region_index = oidx_r;
  assign out_res.mean_value   = omean_r;
  assign out_res.pixel_count  = ocnt_r;
  assign out_res.status       = ostat_r;
  assign out_res.last_result  = olast_r;

endmodule

>>> design/lrm_chk.sv
module lrm_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [lrm_pkg::PIX_W-1:0]         out_mean,
  input logic [lrm_pkg::CNT_O_W-1:0]       out_count,
  input logic                              out_status,
  input logic                              out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean) && $stable(out_count))
    else $error("result dropped while stalled");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == lrm_pkg::STAT_ERR) |->
      (out_mean == '0) && (out_count == '0) && !out_last)
    else $error("error result carries data");

  a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == lrm_pkg::STAT_MEAN) && (out_count == '0) |-> out_mean == '0)
    else $error("empty region with nonzero mean");

  a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("request taken while a result is pending");

endmodule

bind labeled_region_mean lrm_chk u_lrm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_px.ready),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .out_mean   (out_res.mean_value),
  .out_count  (out_res.pixel_count),
  .out_status (out_res.status),
  .out_last   (out_res.last_result)
);
